[hdl/cpra_pkg.sv]
// Package for the contiguous page run allocator.
// Holds payload structs, status and command codes, register indexes and the sequencer states.
// No dependencies.
`default_nettype none

package cpra_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W  = 40;
    localparam int BASE_W  = 39;
    localparam int PAGES_W = 17;
    localparam int SIZE_W  = 32;
    localparam int ST_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = BASE_W;

    // Parameter defaults
    localparam int DEF_MAX_PAGES  = 65536;
    localparam int DEF_PAGE_BYTES = 4096;

    // Register reset values
    localparam logic [BASE_W-1:0]  RST_RANGE_BASE    = '0;
    localparam logic [PAGES_W-1:0] RST_MANAGED_PAGES = 17'd65536;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MANAGED_PAGES = 1'b1;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
    localparam logic [ST_W-1:0] ST_NOMEM = 2'd2;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] byte_size;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] granted_address;
    } t_out_item;

    // Bitmap port request
    typedef struct packed {
        logic we;
        logic re;
        logic wdata;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_SCAN,
        S_VERIFY,
        S_MARK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hdl/cpra_bitmap.sv]
// Page used bitmap: one bit per page, one access per cycle, registered read data.
// Depends on cpra_pkg for the request struct.
`default_nettype none

module cpra_bitmap #(
    parameter int MAX_PAGES = cpra_pkg::DEF_MAX_PAGES
) (
    input  wire                           i_clk,
    input  wire cpra_pkg::t_mem_req       i_req,
    input  wire [$clog2(MAX_PAGES)-1:0]   i_addr,
    output logic                          o_rd_data
);

    logic r_mem [0:MAX_PAGES-1];
    logic r_rd_data;

    // Single port: write or read at one address a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/cpra_ctrl.sv]
// Sequencer and datapath of the allocator: request checks, first fit scan,
// run verify, run mark/clear and the result register. Drives the bitmap port.
// Depends on cpra_pkg.
`default_nettype none

module cpra_ctrl #(
    parameter int MAX_PAGES  = cpra_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = cpra_pkg::DEF_PAGE_BYTES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire cpra_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output cpra_pkg::t_out_item                 o_out_data,
    input  wire [cpra_pkg::BASE_W-1:0]          i_range_base,
    input  wire [$clog2(MAX_PAGES+1)-1:0]       i_npages,
    output cpra_pkg::t_mem_req                  o_mem_req,
    output logic [$clog2(MAX_PAGES)-1:0]        o_mem_addr,
    input  wire                                 i_mem_rd_data
);

    localparam int PW    = $clog2(MAX_PAGES);
    localparam int CW    = $clog2(MAX_PAGES + 1);
    localparam int LOG2PB = $clog2(PAGE_BYTES);
    localparam int AW    = cpra_pkg::ADDR_W;
    localparam int SW    = cpra_pkg::SIZE_W;
    localparam int CNTW  = SW + 1 - LOG2PB;
    localparam int XW    = (CNTW > CW) ? CNTW : CW;

    cpra_pkg::t_state r_state, n_state;

    logic                        r_cmd;
    logic [AW-1:0]               r_addr;
    logic [SW-1:0]               r_size;
    logic [CNTW-1:0]             r_count_w, n_count_w;
    logic [AW-1:0]               r_off, n_off;
    logic                        r_ge, n_ge;
    logic                        r_alig, n_alig;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [PW-1:0]               r_first, n_first;
    logic [PW-1:0]               r_last, n_last;
    logic [CW-1:0]               r_ptr, n_ptr;
    logic [CW-1:0]               r_left, n_left;
    logic [CW-1:0]               r_run, n_run;
    logic                        r_pend, n_pend;
    logic [PW-1:0]               r_pend_addr, n_pend_addr;
    logic                        r_wval, n_wval;
    logic [cpra_pkg::ST_W-1:0]   r_status, n_status;
    logic                        r_res_valid;
    cpra_pkg::t_out_item         r_res;

    logic                        in_acc;
    logic                        res_load;
    logic [SW:0]                 size_sum;
    logic [AW:0]                 off_diff;
    logic [AW-1:0]               cnt_x, np_x, offp_x;
    logic [XW-1:0]               count_xw;
    logic                        alloc_ok, free_ok, chk_ok;
    logic [CW-1:0]               last_page;
    logic [CW-1:0]               run_inc;
    logic                        found;
    logic                        scan_end;
    logic                        ver_fail, ver_pass;
    logic [CW-1:0]               found_first;
    logic [AW-1:0]               page_off;
    logic [AW-1:0]               granted;

    assign in_acc   = (r_state == cpra_pkg::S_IDLE) && i_in_valid;
    assign res_load = (r_state == cpra_pkg::S_DONE) && (!r_res_valid || i_out_ready);

    // Request decode: page count rounded up, offset into the range
    assign size_sum = {1'b0, r_size} + (SW+1)'(PAGE_BYTES - 1);
    assign off_diff = {1'b0, r_addr} - {2'b00, i_range_base};

    // Range checks, all in pages
    assign cnt_x    = {{(AW-CNTW){1'b0}}, r_count_w};
    assign np_x     = {{(AW-CW){1'b0}}, i_npages};
    assign offp_x   = {{LOG2PB{1'b0}}, r_off[AW-1:LOG2PB]};
    assign count_xw = XW'(r_count_w);
    assign alloc_ok = (r_count_w != '0) && (cnt_x <= np_x);
    assign free_ok  = r_alig && r_ge && (r_count_w != '0)
                   && (r_off[LOG2PB-1:0] == '0)
                   && (offp_x < np_x) && (cnt_x <= (np_x - offp_x));
    assign chk_ok   = (r_cmd == cpra_pkg::CMD_ALLOC) ? alloc_ok : free_ok;

    // Scan and verify conditions on the returning bitmap bit
    assign last_page   = i_npages - CW'(1);
    assign run_inc     = r_run + CW'(1);
    assign found       = r_pend && !i_mem_rd_data && (run_inc == r_cnt);
    assign scan_end    = r_pend && ({{(CW-PW){1'b0}}, r_pend_addr} == last_page);
    assign ver_fail    = r_pend && !i_mem_rd_data;
    assign ver_pass    = r_pend && i_mem_rd_data && (r_pend_addr == r_last);
    assign found_first = {{(CW-PW){1'b0}}, r_pend_addr} + CW'(1) - r_cnt;

    // Granted address, wrapping at the address width
    assign page_off = {{(AW-PW){1'b0}}, r_first} << LOG2PB;
    assign granted  = ((r_status == cpra_pkg::ST_OK) && (r_cmd == cpra_pkg::CMD_ALLOC))
                    ? ({1'b0, i_range_base} + page_off) : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpra_pkg::S_CLEAR: begin
                if (r_ptr == CW'(MAX_PAGES - 1)) n_state = cpra_pkg::S_IDLE;
            end
            cpra_pkg::S_IDLE: begin
                if (i_in_valid) n_state = cpra_pkg::S_PREP;
            end
            cpra_pkg::S_PREP: begin
                n_state = cpra_pkg::S_CHECK;
            end
            cpra_pkg::S_CHECK: begin
                if (!chk_ok) n_state = cpra_pkg::S_DONE;
                else if (r_cmd == cpra_pkg::CMD_ALLOC) n_state = cpra_pkg::S_SCAN;
                else n_state = cpra_pkg::S_VERIFY;
            end
            cpra_pkg::S_SCAN: begin
                if (found) n_state = cpra_pkg::S_MARK;
                else if (scan_end) n_state = cpra_pkg::S_DONE;
            end
            cpra_pkg::S_VERIFY: begin
                if (ver_fail) n_state = cpra_pkg::S_DONE;
                else if (ver_pass) n_state = cpra_pkg::S_MARK;
            end
            cpra_pkg::S_MARK: begin
                if (r_left == CW'(1)) n_state = cpra_pkg::S_DONE;
            end
            cpra_pkg::S_DONE: begin
                if (res_load) n_state = cpra_pkg::S_IDLE;
            end
            default: n_state = cpra_pkg::S_CLEAR;
        endcase
    end

    // Datapath next values and bitmap requests
    always_comb begin
        n_count_w   = r_count_w;
        n_off       = r_off;
        n_ge        = r_ge;
        n_alig      = r_alig;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_last      = r_last;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_run       = r_run;
        n_pend      = 1'b0;
        n_pend_addr = r_ptr[PW-1:0];
        n_wval      = r_wval;
        n_status    = r_status;
        o_mem_req   = '0;
        o_mem_addr  = r_ptr[PW-1:0];
        case (r_state)
            cpra_pkg::S_CLEAR: begin
                o_mem_req.we = 1'b1;
                n_ptr        = r_ptr + CW'(1);
            end
            cpra_pkg::S_PREP: begin
                n_count_w = size_sum[SW:LOG2PB];
                n_off     = off_diff[AW-1:0];
                n_ge      = !off_diff[AW];
                n_alig    = (r_addr[LOG2PB-1:0] == '0);
            end
            cpra_pkg::S_CHECK: begin
                n_cnt  = count_xw[CW-1:0];
                n_run  = '0;
                n_left = count_xw[CW-1:0];
                if (!chk_ok) begin
                    n_status = cpra_pkg::ST_BAD;
                end else if (r_cmd == cpra_pkg::CMD_ALLOC) begin
                    n_status = cpra_pkg::ST_NOMEM;
                    n_ptr    = '0;
                end else begin
                    n_status = cpra_pkg::ST_BAD;
                    n_first  = r_off[PW+LOG2PB-1:LOG2PB];
                    n_last   = r_off[PW+LOG2PB-1:LOG2PB] + count_xw[PW-1:0] - PW'(1);
                    n_ptr    = {{(CW-PW){1'b0}}, r_off[PW+LOG2PB-1:LOG2PB]};
                end
            end
            cpra_pkg::S_SCAN: begin
                // Issue the next page while the previous bit comes back
                if (r_ptr != i_npages) begin
                    o_mem_req.re = 1'b1;
                    n_pend       = 1'b1;
                    n_ptr        = r_ptr + CW'(1);
                end
                if (r_pend) begin
                    n_run = i_mem_rd_data ? '0 : run_inc;
                end
                if (found) begin
                    n_first  = found_first[PW-1:0];
                    n_ptr    = found_first;
                    n_left   = r_cnt;
                    n_wval   = 1'b1;
                    n_status = cpra_pkg::ST_OK;
                    n_pend   = 1'b0;
                end
            end
            cpra_pkg::S_VERIFY: begin
                if (r_left != '0) begin
                    o_mem_req.re = 1'b1;
                    n_pend       = 1'b1;
                    n_ptr        = r_ptr + CW'(1);
                    n_left       = r_left - CW'(1);
                end
                if (ver_pass) begin
                    n_ptr    = {{(CW-PW){1'b0}}, r_first};
                    n_left   = r_cnt;
                    n_wval   = 1'b0;
                    n_status = cpra_pkg::ST_OK;
                    n_pend   = 1'b0;
                end
            end
            cpra_pkg::S_MARK: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = r_wval;
                n_ptr           = r_ptr + CW'(1);
                n_left          = r_left - CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpra_pkg::S_CLEAR;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_pend  <= n_pend;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_in_data.command;
            r_addr <= i_in_data.address;
            r_size <= i_in_data.byte_size;
        end
        r_count_w   <= n_count_w;
        r_off       <= n_off;
        r_ge        <= n_ge;
        r_alig      <= n_alig;
        r_cnt       <= n_cnt;
        r_first     <= n_first;
        r_last      <= n_last;
        r_left      <= n_left;
        r_run       <= n_run;
        r_pend_addr <= n_pend_addr;
        r_wval      <= n_wval;
        r_status    <= n_status;
        if (res_load) begin
            r_res.status          <= r_status;
            r_res.granted_address <= granted;
        end
    end

    assign o_in_ready  = (r_state == cpra_pkg::S_IDLE);
    assign o_out_valid = r_res_valid;
    assign o_out_data  = r_res;

`ifndef SYNTHESIS
    // One port: never a read and a write together
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("bitmap read and write in one cycle");

    // A run being marked always has pages left
    a_mark_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpra_pkg::S_MARK) |-> (r_left != '0))
        else $error("mark phase with no pages left");

    // A result leaving the sequencer lands in the output register
    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> (r_res_valid && (r_state == cpra_pkg::S_IDLE)))
        else $error("result not registered");

    // Returning read data only follows a scan or verify cycle
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == cpra_pkg::S_SCAN
                 || $past(r_state) == cpra_pkg::S_VERIFY))
        else $error("read data pending outside scan or verify");
`endif

endmodule

`default_nettype wire

[hdl/contiguous_page_run_allocator_unit.sv]
// Top level of the contiguous page run allocator: configuration registers,
// page count clamp, sequencer and page bitmap. Depends on cpra_pkg, cpra_ctrl, cpra_bitmap.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------
//  request  | in        | i_in_valid / o_in_ready | i_in_data (command, address, byte_size)
//  result   | out       | o_out_valid / i_out_ready | o_out_data (status, granted_address)
//  config   | in        | i_cfg_we, no wait      | i_cfg_index, i_cfg_wdata
//
// The bitmap is read or written one page a cycle through a single port, which sets all timing.
// Allocate: request checks, first fit scan, mark pass over the run, then the result.
// Free: request checks, verify reads of the run, clear pass over the run, then the result.
// After reset a clearing pass over all MAX_PAGES pages runs before the first request is taken.
// One request at a time; a result waits in its register while the next request is taken.
`default_nettype none

module contiguous_page_run_allocator_unit #(
    parameter int MAX_PAGES  = cpra_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = cpra_pkg::DEF_PAGE_BYTES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire cpra_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output cpra_pkg::t_out_item                 o_out_data,
    input  wire                                 i_cfg_we,
    input  wire [cpra_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [cpra_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int PW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int MW = (CW > cpra_pkg::PAGES_W) ? CW : cpra_pkg::PAGES_W;

    logic [cpra_pkg::BASE_W-1:0]  r_range_base;
    logic [cpra_pkg::PAGES_W-1:0] r_managed_pages;
    logic [MW-1:0]                mp_x;
    logic [CW-1:0]                npages;
    cpra_pkg::t_mem_req           mem_req;
    logic [PW-1:0]                mem_addr;
    logic                         mem_rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_base    <= cpra_pkg::RST_RANGE_BASE;
            r_managed_pages <= cpra_pkg::RST_MANAGED_PAGES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cpra_pkg::REG_RANGE_BASE:    r_range_base    <= i_cfg_wdata;
                cpra_pkg::REG_MANAGED_PAGES: r_managed_pages <= i_cfg_wdata[cpra_pkg::PAGES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Live page count, limited to the bitmap depth
    assign mp_x   = MW'(r_managed_pages);
    assign npages = (mp_x > MW'(MAX_PAGES)) ? CW'(MAX_PAGES) : mp_x[CW-1:0];

    cpra_ctrl #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .i_range_base  (r_range_base),
        .i_npages      (npages),
        .o_mem_req     (mem_req),
        .o_mem_addr    (mem_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    cpra_bitmap #(
        .MAX_PAGES (MAX_PAGES)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .i_addr    (mem_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

[bench/tb_contiguous_page_run_allocator_unit.sv]
// Self-checking testbench for contiguous_page_run_allocator_unit: first fit page runs, frees,
// range settings. Holds its own bitmap of used pages to predict every result transaction.
// Depends on cpra_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb_contiguous_page_run_allocator_unit;

    localparam int              MAX_PAGE_COUNT = cpra_pkg::DEF_MAX_PAGES;
    localparam longint unsigned PAGE_SZ        = cpra_pkg::DEF_PAGE_BYTES;
    localparam int unsigned     PAGE_U         = cpra_pkg::DEF_PAGE_BYTES;
    localparam longint unsigned ADDR_MASK      = 64'h00FF_FFFF_FFFF;
    localparam logic [cpra_pkg::SIZE_W-1:0] FULL_RANGE_BYTES =
        cpra_pkg::SIZE_W'(cpra_pkg::DEF_MAX_PAGES * cpra_pkg::DEF_PAGE_BYTES);
    localparam logic [cpra_pkg::BASE_W-1:0] TOP_ALIGNED_BASE = 39'h7F_FFFF_F000;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 250;

    typedef struct {
        int unsigned first;
        int unsigned pages;
    } t_run;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_PATTERN,
        READY_COIN
    } t_ready_mode;

    // Mirror of the page bitmap and range registers; predicts and checks results
    class page_map_tracker;
        bit                           page_taken [MAX_PAGE_COUNT];
        logic [cpra_pkg::BASE_W-1:0]  range_base;
        logic [cpra_pkg::PAGES_W-1:0] managed_pages;
        cpra_pkg::t_out_item          awaited_results [$];
        int unsigned mismatches, requests, granted, released, refused, no_room;

        function new();
            foreach (page_taken[p]) page_taken[p] = 1'b0;
            range_base    = cpra_pkg::RST_RANGE_BASE;
            managed_pages = cpra_pkg::RST_MANAGED_PAGES;
        endfunction

        function void set_register(logic [cpra_pkg::CFG_IDX_W-1:0] idx,
                                   logic [cpra_pkg::CFG_DATA_W-1:0] value);
            if (idx == cpra_pkg::REG_RANGE_BASE) begin
                range_base = value[cpra_pkg::BASE_W-1:0];
            end else begin
                managed_pages = value[cpra_pkg::PAGES_W-1:0];
            end
        endfunction

        // Counts above the store depth behave as the full store
        function longint unsigned live_pages();
            return (managed_pages > MAX_PAGE_COUNT) ? longint'(MAX_PAGE_COUNT)
                                                    : longint'(managed_pages);
        endfunction

        // Works out the result of one accepted request and queues it
        function cpra_pkg::t_out_item note_request(cpra_pkg::t_in_item req);
            cpra_pkg::t_out_item res;
            longint unsigned npages, span, count, run, first, off, nbytes, addr, base, p, sum;
            bit              all_used;
            npages = live_pages();
            span   = npages * PAGE_SZ;
            count  = (64'(req.byte_size) + PAGE_SZ - 1) / PAGE_SZ;
            res.status          = cpra_pkg::ST_BAD;
            res.granted_address = '0;
            requests++;
            if (req.command == cpra_pkg::CMD_ALLOC) begin
                // first fit: lowest run of free pages long enough
                if (count != 0 && count <= npages) begin
                    res.status = cpra_pkg::ST_NOMEM;
                    run = 0;
                    for (p = 0; p < npages; p++) begin
                        if (page_taken[p]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == count) begin
                                first = p + 1 - count;
                                for (p = first; p < first + count; p++) page_taken[p] = 1'b1;
                                sum = 64'(range_base) + first * PAGE_SZ;
                                res.granted_address = sum[cpra_pkg::ADDR_W-1:0];
                                res.status = cpra_pkg::ST_OK;
                                break;
                            end
                        end
                    end
                end
            end else begin
                // free: aligned, on the page grid of the base, inside the range, all pages used
                addr   = 64'(req.address);
                base   = 64'(range_base);
                off    = addr - base;
                nbytes = count * PAGE_SZ;
                if (addr % PAGE_SZ == 0 && addr >= base && count != 0 && off < span
                        && nbytes <= span - off && off % PAGE_SZ == 0) begin
                    first    = off / PAGE_SZ;
                    all_used = 1'b1;
                    for (p = first; p < first + count; p++) begin
                        if (!page_taken[p]) all_used = 1'b0;
                    end
                    if (all_used) begin
                        for (p = first; p < first + count; p++) page_taken[p] = 1'b0;
                        res.status = cpra_pkg::ST_OK;
                    end
                end
            end
            if (res.status == cpra_pkg::ST_OK) begin
                if (req.command == cpra_pkg::CMD_ALLOC) granted++;
                else released++;
            end else if (res.status == cpra_pkg::ST_NOMEM) begin
                no_room++;
            end else begin
                refused++;
            end
            awaited_results.push_back(res);
            return res;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(cpra_pkg::t_out_item got);
            cpra_pkg::t_out_item want;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result with none outstanding, status %0d addr 0x%010h",
                                          got.status, got.granted_address));
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.granted_address !== want.granted_address)
                report_mismatch($sformatf("granted_address 0x%010h, expected 0x%010h",
                                          got.granted_address, want.granted_address));
        endtask
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    cpra_pkg::t_in_item              i_in_data   = '0;
    logic                            i_out_ready = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [cpra_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [cpra_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    cpra_pkg::t_out_item             o_out_data;

    page_map_tracker board = new();
    t_run            runs [$];
    int              burst_left = 0;
    int              idle_cycles = 0;
    int              settings_written = 0;
    logic [4:0]      stall_left = '0;
    t_ready_mode     stall_mode = READY_ALWAYS;
    logic [31:0]     stall_bits = '0;

    contiguous_page_run_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Result side: stall mode redrawn whenever stall_left reaches zero
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_ready_mode'($urandom_range(0, 2));
            stall_bits <= $urandom;
        end
        stall_left <= stall_left - 1'b1;
        case (stall_mode)
            READY_ALWAYS:  i_out_ready <= 1'b1;
            READY_PATTERN: i_out_ready <= stall_bits[stall_left];
            default:       i_out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_out_data);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic cpra_pkg::t_in_item make_request(logic cmd,
                                                        logic [cpra_pkg::ADDR_W-1:0] addr,
                                                        logic [cpra_pkg::SIZE_W-1:0] size);
        cpra_pkg::t_in_item req;
        req.command   = cmd;
        req.address   = addr;
        req.byte_size = size;
        return req;
    endfunction

    // Sends one request in burst/gap pacing, predicts it and tracks live runs
    task automatic issue(input cpra_pkg::t_in_item req);
        cpra_pkg::t_out_item outcome;
        longint unsigned     count, first, offset;
        int unsigned         gap;
        int                  k;
        t_run                fresh;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        outcome = board.note_request(req);
        count   = (64'(req.byte_size) + PAGE_SZ - 1) / PAGE_SZ;
        if (outcome.status == cpra_pkg::ST_OK) begin
            if (req.command == cpra_pkg::CMD_ALLOC) begin
                offset = (64'(outcome.granted_address) - 64'(board.range_base)) & ADDR_MASK;
                fresh.first = 32'(offset / PAGE_SZ);
                fresh.pages = 32'(count);
                runs.push_back(fresh);
            end else begin
                first = (64'(req.address) - 64'(board.range_base)) / PAGE_SZ;
                for (k = runs.size() - 1; k >= 0; k--) begin
                    if (runs[k].first >= first && runs[k].first < first + count) runs.delete(k);
                end
            end
        end
    endtask

    // Holds the request side idle until every result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Both registers, one per cycle, only while idle
    task automatic write_settings(logic [cpra_pkg::BASE_W-1:0] base,
                                  logic [cpra_pkg::PAGES_W-1:0] pages);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= cpra_pkg::REG_RANGE_BASE;
        i_cfg_wdata <= cpra_pkg::CFG_DATA_W'(base);
        @(posedge i_clk);
        board.set_register(cpra_pkg::REG_RANGE_BASE, cpra_pkg::CFG_DATA_W'(base));
        i_cfg_index <= cpra_pkg::REG_MANAGED_PAGES;
        i_cfg_wdata <= cpra_pkg::CFG_DATA_W'(pages);
        @(posedge i_clk);
        board.set_register(cpra_pkg::REG_MANAGED_PAGES, cpra_pkg::CFG_DATA_W'(pages));
        i_cfg_we <= 1'b0;
        settings_written++;
    endtask

    // Mostly well formed allocs and frees of live runs, the rest broken or noise
    function automatic cpra_pkg::t_in_item random_request();
        cpra_pkg::t_in_item req;
        longint unsigned    npages, count, spot, addr64;
        int unsigned        pick;
        t_run               r;
        npages        = board.live_pages();
        req.command   = cpra_pkg::CMD_ALLOC;
        req.address   = cpra_pkg::ADDR_W'({$urandom, $urandom});
        req.byte_size = '0;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            case ($urandom_range(0, 19))
                0: req.byte_size = '0;
                1: req.byte_size = cpra_pkg::SIZE_W'(npages * PAGE_SZ);
                2: req.byte_size = cpra_pkg::SIZE_W'(npages * PAGE_SZ
                                                     + $urandom_range(1, PAGE_U));
                3: req.byte_size = $urandom;
                default: begin
                    count = $urandom_range(1, (npages >= 8) ? 32'(npages / 4) : 1);
                    req.byte_size = cpra_pkg::SIZE_W'(count * PAGE_SZ
                                                      - $urandom_range(0, PAGE_U - 1));
                end
            endcase
        end else if (pick < 85 && runs.size() != 0) begin
            r = runs[$urandom_range(0, runs.size() - 1)];
            addr64 = 64'(board.range_base) + 64'(r.first) * PAGE_SZ;
            req.command   = cpra_pkg::CMD_FREE;
            req.address   = addr64[cpra_pkg::ADDR_W-1:0];
            req.byte_size = cpra_pkg::SIZE_W'(64'(r.pages) * PAGE_SZ
                                              - $urandom_range(0, PAGE_U - 1));
            // now and then one page too many
            if ($urandom_range(0, 9) == 0)
                req.byte_size = req.byte_size + cpra_pkg::SIZE_W'(PAGE_SZ);
        end else if ($urandom_range(0, 1) == 0) begin
            // free near the range, sometimes off the page grid
            spot   = $urandom_range(0, 32'(npages));
            addr64 = 64'(board.range_base) + spot * PAGE_SZ;
            if ($urandom_range(0, 1) == 0) addr64 = addr64 + $urandom_range(1, PAGE_U - 1);
            req.command   = cpra_pkg::CMD_FREE;
            req.address   = addr64[cpra_pkg::ADDR_W-1:0];
            req.byte_size = cpra_pkg::SIZE_W'($urandom_range(1, 8) * PAGE_U);
        end else begin
            req.command   = 1'($urandom_range(0, 1));
            req.byte_size = $urandom;
        end
        return req;
    endfunction

    initial begin : stimulus
        logic [cpra_pkg::BASE_W-1:0] base;
        int                          phase, n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full store at base zero
        issue(make_request(cpra_pkg::CMD_ALLOC, '1, cpra_pkg::SIZE_W'(1)));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, FULL_RANGE_BYTES + 1'b1));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, '0));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, '1));
        issue(make_request(cpra_pkg::CMD_FREE, '0, '0));
        issue(make_request(cpra_pkg::CMD_FREE, cpra_pkg::ADDR_W'(1),
                           cpra_pkg::SIZE_W'(PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_FREE, cpra_pkg::ADDR_W'(PAGE_SZ),
                           cpra_pkg::SIZE_W'(PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_FREE, '1, '1));
        issue(make_request(cpra_pkg::CMD_FREE,
                           cpra_pkg::ADDR_W'((MAX_PAGE_COUNT - 1) * PAGE_SZ),
                           cpra_pkg::SIZE_W'(2 * PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_FREE, '0, cpra_pkg::SIZE_W'(1)));
        issue(make_request(cpra_pkg::CMD_FREE, '0, cpra_pkg::SIZE_W'(PAGE_SZ)));

        // Page count beyond the store, base near the top: whole range in one run
        wait_drained();
        write_settings(TOP_ALIGNED_BASE, '1);
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, FULL_RANGE_BYTES));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, cpra_pkg::SIZE_W'(1)));
        issue(make_request(cpra_pkg::CMD_FREE, '0, cpra_pkg::SIZE_W'(PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_FREE, {1'b0, TOP_ALIGNED_BASE}, FULL_RANGE_BYTES));

        // No pages at all, unaligned base
        wait_drained();
        write_settings('1, '0);
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, cpra_pkg::SIZE_W'(PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_FREE, 40'h7F_FFFF_FFFF, cpra_pkg::SIZE_W'(PAGE_SZ)));

        // One page, unaligned base: the granted run cannot be freed here
        wait_drained();
        write_settings('1, cpra_pkg::PAGES_W'(1));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, cpra_pkg::SIZE_W'(PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, cpra_pkg::SIZE_W'(1)));
        issue(make_request(cpra_pkg::CMD_FREE, 40'h80_0000_0000, cpra_pkg::SIZE_W'(PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_FREE, 40'h7F_FFFF_FFFF, cpra_pkg::SIZE_W'(PAGE_SZ)));

        // Range moved back to zero: the used bit survives the change
        wait_drained();
        write_settings('0, cpra_pkg::PAGES_W'(2));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, cpra_pkg::SIZE_W'(2 * PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_FREE, '0, cpra_pkg::SIZE_W'(PAGE_SZ)));
        issue(make_request(cpra_pkg::CMD_ALLOC, '0, cpra_pkg::SIZE_W'(2 * PAGE_SZ)));

        // Random phases over small ranges, mostly aligned bases
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            base = cpra_pkg::BASE_W'({$urandom, $urandom});
            if ($urandom_range(0, 5) != 0) base[11:0] = '0;
            write_settings(base, cpra_pkg::PAGES_W'($urandom_range(1, 160)));
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                if ($urandom_range(0, 49) == 0) wait_drained();
                issue(random_request());
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (board.awaited_results.size() != 0)
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.awaited_results.size()));
        $display("Covered %0d requests over %0d range settings: %0d runs granted, %0d released,",
                 board.requests, settings_written + 1, board.granted, board.released);
        $display("%0d refused as bad values, %0d turned away for want of a free run.",
                 board.refused, board.no_room);
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/cpra_pkg.sv
hdl/cpra_bitmap.sv
hdl/cpra_ctrl.sv
hdl/contiguous_page_run_allocator_unit.sv
bench/tb_contiguous_page_run_allocator_unit.sv
